[src/paged_mono_framebuffer_blit_refresh_assert.svh]
// Assertion macros for the paged monochrome frame buffer.
// Uses the clk and rst_n names of the including module.
`ifndef PAGED_MONO_FRAMEBUFFER_BLIT_REFRESH_ASSERT_SVH
`define PAGED_MONO_FRAMEBUFFER_BLIT_REFRESH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMFB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/pmfb_pkg.sv]
// Shared types and constants for the paged monochrome frame buffer.
// No dependencies; imported by the controller, datapath and top level.
package pmfb_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PLOT    = 2'd1,
    OP_GLYPH   = 2'd2,
    OP_REFRESH = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PX_RD,
    S_PX_WR,
    S_RF_OUT
  } ctl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture the transaction fields
    logic rd_refresh;  // memory read address from the refresh pointer
    logic clr_step;    // write zero at the sweep address, advance
    logic px_wr;       // write back the modified byte, advance pixel
    logic rf_emit;     // register one stream byte, advance refresh pointer
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic px_last;
    logic glyph_empty;
  } stat_t;

  localparam logic [7:0] CMD_PAGE    = 8'hB0;
  localparam logic [7:0] CMD_COL_HI  = 8'h10;
  localparam logic [7:0] CMD_COL_LO  = 8'h00;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam int         NARROW_BITS = 8;
  localparam int         CMD_BYTES   = 3;

endpackage

[src/pmfb_ctrl.sv]
// Sequencing state machine for the paged monochrome frame buffer.
// Depends on pmfb_pkg (state enum, command and status structs).
module pmfb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  pmfb_pkg::stat_t stat,
  output logic            busy,
  output pmfb_pkg::cmd_t  cmd
);
  import pmfb_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;  // clearing pass after reset
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (opcode_t'(opcode))
            OP_CLEAR:   state_nxt = S_CLEAR;
            OP_PLOT:    state_nxt = S_PX_RD;
            OP_GLYPH:   state_nxt = stat.glyph_empty ? S_IDLE : S_PX_RD;
            OP_REFRESH: state_nxt = S_RF_OUT;
          endcase
        end
      end
      S_PX_RD:  state_nxt = S_PX_WR;
      S_PX_WR:  state_nxt = stat.px_last ? S_IDLE : S_PX_RD;
      S_RF_OUT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    unique case (state_r)
      S_CLEAR:  cmd.clr_step = 1'b1;
      S_IDLE: begin
        busy           = 1'b0;
        cmd.load       = start;
        cmd.rd_refresh = 1'b1;
      end
      S_PX_RD:  ;
      S_PX_WR:  cmd.px_wr = 1'b1;
      S_RF_OUT: cmd.rf_emit = 1'b1;
      default:  ;
    endcase
  end

endmodule

[src/pmfb_datapath.sv]
// Frame memory, pixel read-modify-write path and refresh stream output.
// Depends on pmfb_pkg (command and status structs, stream constants).
module pmfb_datapath #(
  parameter int COLUMNS         = 128,
  parameter int ROWS            = 32,
  parameter int MAX_GLYPH_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pmfb_pkg::cmd_t     cmd,
  output pmfb_pkg::stat_t    stat,
  input  logic [1:0]         in_opcode,
  input  logic signed [8:0]  in_pos_x,
  input  logic signed [6:0]  in_pos_y,
  input  logic               in_pixel_color,
  input  logic [4:0]         in_glyph_width,
  input  logic [15:0]        in_glyph_row_bits,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_is_data,
  output logic               out_last_of_frame
);
  import pmfb_pkg::*;

  localparam int PAGES       = (ROWS + 7) / 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int PGW         = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int POSW        = $clog2(COLUMNS + CMD_BYTES);

  // frame memory, one write and one registered read per cycle
  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr, px_addr, rf_addr;
  logic [7:0]    wr_data;
  logic          wr_en;

  logic [AW-1:0]       clr_addr_r;
  logic signed [9:0]   cur_x_r;
  logic signed [6:0]   y_r;
  logic [15:0]         sh_r;
  logic [4:0]          px_cnt_r;
  logic [PGW-1:0]      page_r;
  logic [POSW-1:0]     pos_r;
  logic [POSW-1:0]     rf_col;

  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_is_data_r;
  logic                out_last_r;

  logic [4:0]          w_sat;
  logic                px_on;
  logic [7:0]          bit_mask;
  logic [7:0]          rf_byte;
  logic                rf_data, rf_last, rf_wrap;

  // glyph width saturates to the maximum
  assign w_sat = (in_glyph_width > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH)
                                                        : in_glyph_width;

  assign stat.clr_last    = (clr_addr_r == AW'(STORE_BYTES - 1));
  assign stat.px_last     = (px_cnt_r == 5'd1);
  assign stat.glyph_empty = (in_glyph_width == 5'd0);

  // pixel clipping and addressing
  assign px_on = !cur_x_r[9] && (cur_x_r[8:0] < 9'(COLUMNS))
              && !y_r[6] && ({1'b0, y_r[5:0]} < 7'(ROWS));
  assign px_addr  = AW'(int'(y_r[5:3]) * COLUMNS + int'(cur_x_r[8:0]));
  assign bit_mask = 8'b1 << y_r[2:0];

  // refresh addressing, column offset past the command bytes
  assign rf_col  = (pos_r >= POSW'(CMD_BYTES)) ? pos_r - POSW'(CMD_BYTES) : '0;
  assign rf_addr = AW'(int'(page_r) * COLUMNS + int'(rf_col));

  assign rd_addr = cmd.rd_refresh ? rf_addr : px_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = px_addr;
    wr_data = sh_r[15] ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (cmd.px_wr && px_on) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // clearing sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= stat.clr_last ? '0 : clr_addr_r + AW'(1);
    end
  end

  // pixel walker: position, remaining count, bit shifter (MSB is next pixel)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= 10'(in_pos_x);
      y_r     <= in_pos_y;
      if (in_opcode == OP_PLOT) begin
        sh_r     <= {in_pixel_color, 15'b0};
        px_cnt_r <= 5'd1;
      end else begin
        sh_r     <= (w_sat <= 5'(NARROW_BITS)) ? {in_glyph_row_bits[7:0], 8'h00}
                                               : in_glyph_row_bits;
        px_cnt_r <= w_sat;
      end
    end else if (cmd.px_wr) begin
      cur_x_r  <= cur_x_r + 10'sd1;
      sh_r     <= {sh_r[14:0], 1'b0};
      px_cnt_r <= px_cnt_r - 5'd1;
    end
  end

  // refresh stream byte
  assign rf_last = (page_r == PGW'(PAGES - 1)) && (pos_r == POSW'(COLUMNS + 2));
  assign rf_wrap = (pos_r == POSW'(COLUMNS + 2));

  always_comb begin
    rf_data = 1'b0;
    priority if (pos_r == POSW'(0)) begin
      rf_byte = CMD_PAGE | (8'(page_r) & LOW_NIBBLE);
    end else if (pos_r == POSW'(1)) begin
      rf_byte = CMD_COL_HI;
    end else if (pos_r == POSW'(2)) begin
      rf_byte = CMD_COL_LO;
    end else begin
      rf_byte = rd_data_r;
      rf_data = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0;
      pos_r  <= '0;
    end else if (cmd.rf_emit) begin
      if (rf_wrap) begin
        pos_r  <= '0;
        page_r <= (page_r == PGW'(PAGES - 1)) ? '0 : page_r + PGW'(1);
      end else begin
        pos_r <= pos_r + POSW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rf_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_emit) begin
      out_byte_r    <= rf_byte;
      out_is_data_r <= rf_data;
      out_last_r    <= rf_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_is_data       = out_is_data_r;
  assign out_last_of_frame = out_last_r;

endmodule

[src/paged_mono_framebuffer_blit_refresh.sv]
// Refresh step: the strobe follows the S_RF_OUT state and its output register.
// Plot and glyph row: busy for a read, then a write, per pixel; a new transaction
//   (a refresh step included) is taken once busy drops.
// Clear: busy while every byte of the frame memory is zeroed in turn.
// Reset (rst_n low, synchronous) zeroes the refresh pointer, then runs the same
// clearing pass with busy high. Results cannot be held off.
`include "paged_mono_framebuffer_blit_refresh_assert.svh"

module paged_mono_framebuffer_blit_refresh #(
  parameter int COLUMNS         = 128,
  parameter int ROWS            = 32,
  parameter int MAX_GLYPH_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic signed [8:0] in_pos_x,
  input  logic signed [6:0] in_pos_y,
  input  logic              in_pixel_color,
  input  logic [4:0]        in_glyph_width,
  input  logic [15:0]       in_glyph_row_bits,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_is_data,
  output logic              out_last_of_frame
);
  import pmfb_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  accept_rf, accept_draw;

  pmfb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  pmfb_datapath #(
    .COLUMNS         (COLUMNS),
    .ROWS            (ROWS),
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pixel_color    (in_pixel_color),
    .in_glyph_width    (in_glyph_width),
    .in_glyph_row_bits (in_glyph_row_bits),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_last_of_frame (out_last_of_frame)
  );

  assign accept_rf   = start && !busy && (in_opcode == OP_REFRESH);
  assign accept_draw = start && !busy && (in_opcode != OP_REFRESH);

  // every refresh transaction yields a byte after the S_RF_OUT state and the output register
  `PMFB_ASSERT_IMPL(a_refresh_result, accept_rf, ##2 out_valid, "refresh step lost its result")
  // drawing and clearing transactions never produce a byte
  `PMFB_ASSERT_IMPL(a_no_draw_result, accept_draw, ##2 !out_valid, "non-refresh result")
  // each refresh step returns through S_IDLE, so strobes never touch
  `PMFB_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid, "back-to-back result strobes")

endmodule
